/* rtl/spvl_pkg.sv */
// ----------------------------------------------------------------------------
// spvl_pkg
// Shared types, result codes and helpers for the sorted pending version list.
// ----------------------------------------------------------------------------
`default_nettype none

package spvl_pkg;

	localparam int VER_W  = 64;
	localparam int KIND_W = 2;
	localparam int HELD_W = 5;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_INSERT  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_REMOVED = 2'd1;
	localparam logic [KIND_W-1:0] KIND_NONE    = 2'd2;

	// input operations
	localparam logic OP_START  = 1'b0;
	localparam logic OP_FINISH = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INS_RD,
		ST_INS_CMP,
		ST_ACK,
		ST_FIN_RD,
		ST_FIN_CMP,
		ST_NONE,
		ST_EMIT_RD,
		ST_EMIT_OUT
	} spvl_state_t;

	// one result beat offered by the sequencer to the output register
	typedef struct packed {
		logic              valid;
		logic [KIND_W-1:0] kind;
		logic [VER_W-1:0]  ver;
		logic [HELD_W-1:0] held;
		logic              last;
	} spvl_beat_t;

	// signed less-than on two's complement patterns
	function automatic logic sless(input logic [VER_W-1:0] a, input logic [VER_W-1:0] b);
		return $signed(a) < $signed(b);
	endfunction

endpackage

`default_nettype wire

/* rtl/sorted_pending_version_list.sv */
// ----------------------------------------------------------------------------
// sorted_pending_version_list
// Bounded ascending list of pending versions: start beats insert, finish
// beats remove and report the leading run at or below the given version.
// ----------------------------------------------------------------------------
//
//  channel | signals                                   | flow control
//  --------+-------------------------------------------+-----------------
//  in      | operation, version                        | in_valid/in_stall
//  out     | kind, removed_version, entries_held, last | out_valid/out_stall
//
// Steps: a start beat reads, then compares and writes, once per held entry
//   at or above its version, shifting each up a slot; it then writes the
//   version and sends the ack. A finish beat makes one scan pass that counts
//   the run and a second pass that reads and reports it; a finish removing
//   nothing sends one none result. Both passes share the single read port of
//   the entry store; the scan and the insertion share one signed comparator.
//   The next beat is taken in the idle state after the last result is handed on.
// Reset: arst_n clears the sequencer, head pointer and entry count; the entry
//   store itself is not cleared (only slots below the count are ever read).
// Stalls: in_stall is high while an item is in progress. Results go through
//   an output register, so a new item can be taken while one beat waits; a
//   stalled output beat holds the sequencer in its ack, none or report state.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_pending_version_list
	import spvl_pkg::*;
#(
	parameter int LIST_DEPTH = 16
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire logic                    operation,
	input  wire logic signed [VER_W-1:0] version,
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output logic             [KIND_W-1:0] kind,
	output logic signed      [VER_W-1:0] removed_version,
	output logic             [HELD_W-1:0] entries_held,
	output logic                         last
);

	localparam int ADDR_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int CNT_W  = $clog2(LIST_DEPTH + 1);

	logic              busy;
	spvl_beat_t        emit;
	logic              emit_rdy;
	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [VER_W-1:0]  wdata;
	logic              re;
	logic [ADDR_W-1:0] raddr;
	logic [VER_W-1:0]  rdata;

	// output register
	logic              out_valid_q;
	logic [KIND_W-1:0] kind_q;
	logic [VER_W-1:0]  ver_q;
	logic [HELD_W-1:0] held_q;
	logic              last_q;

	assign in_stall = busy;

	// output slot free when empty or being drained this cycle
	assign emit_rdy = !out_valid_q || !out_stall;

	spvl_seq #(
		.LIST_DEPTH (LIST_DEPTH),
		.ADDR_W     (ADDR_W),
		.CNT_W      (CNT_W)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.operation (operation),
		.version   (version),
		.busy      (busy),
		.emit      (emit),
		.emit_rdy  (emit_rdy),
		.we        (we),
		.waddr     (waddr),
		.wdata     (wdata),
		.re        (re),
		.raddr     (raddr),
		.rdata     (rdata)
	);

	spvl_ram #(
		.DEPTH  (LIST_DEPTH),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_rdy) begin
			out_valid_q <= emit.valid;
		end
	end

	// payload loads only when a beat is handed over
	always_ff @(posedge clk) begin
		if (emit_rdy && emit.valid) begin
			kind_q <= emit.kind;
			ver_q  <= emit.ver;
			held_q <= emit.held;
			last_q <= emit.last;
		end
	end

	assign out_valid       = out_valid_q;
	assign kind            = kind_q;
	assign removed_version = ver_q;
	assign entries_held    = held_q;
	assign last            = last_q;

endmodule

`default_nettype wire

/* rtl/spvl_ram.sv */
// ----------------------------------------------------------------------------
// spvl_ram
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module spvl_ram
	import spvl_pkg::*;
#(
	parameter int DEPTH  = 16,
	parameter int ADDR_W = 4
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [VER_W-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [VER_W-1:0]  rdata
);

	logic [VER_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* rtl/spvl_seq.sv */
// ----------------------------------------------------------------------------
// spvl_seq
// Sequencer: circular-buffer bookkeeping, insertion shift and removal scan
// through one shared signed comparator.
// ----------------------------------------------------------------------------
`default_nettype none

module spvl_seq
	import spvl_pkg::*;
#(
	parameter int LIST_DEPTH = 16,
	parameter int ADDR_W     = 4,
	parameter int CNT_W      = 5
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              operation,
	input  wire logic [VER_W-1:0]  version,
	output logic                   busy,
	output spvl_beat_t             emit,
	input  wire logic              emit_rdy,
	output logic                   we,
	output logic      [ADDR_W-1:0] waddr,
	output logic      [VER_W-1:0]  wdata,
	output logic                   re,
	output logic      [ADDR_W-1:0] raddr,
	input  wire logic [VER_W-1:0]  rdata
);

	spvl_state_t       state_q, state_d;
	logic [ADDR_W-1:0] hd_q, hd_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [CNT_W-1:0]  idx_q, idx_d;
	logic [CNT_W-1:0]  run_q, run_d;
	logic [VER_W-1:0]  ver_q, ver_d;
	logic [CNT_W-1:0]  idx_m1;
	logic [CNT_W-1:0]  idx_p1;
	logic [CNT_W-1:0]  cnt_left;
	logic              last_beat;
	logic              is_full;
	logic              cmp_swap;
	logic [VER_W-1:0]  cmp_a;
	logic [VER_W-1:0]  cmp_b;
	logic              cmp_lt;

	// logical position -> physical slot (base + pos, wrapped once)
	function automatic logic [ADDR_W-1:0] phys(input logic [ADDR_W-1:0] base,
	                                           input logic [CNT_W-1:0]  pos);
		logic [ADDR_W:0] s;
		s = {1'b0, base} + (ADDR_W+1)'(pos);
		if (s >= (ADDR_W+1)'(LIST_DEPTH)) begin
			s = s - (ADDR_W+1)'(LIST_DEPTH);
		end
		return s[ADDR_W-1:0];
	endfunction

	assign idx_m1    = idx_q - CNT_W'(1);
	assign idx_p1    = idx_q + CNT_W'(1);
	assign cnt_left  = cnt_q - run_q;
	assign last_beat = (idx_p1 == run_q);
	assign is_full   = (cnt_q == CNT_W'(LIST_DEPTH));
	assign busy      = (state_q != ST_IDLE);

	// shared comparator: insert asks entry < version, removal asks
	// version < entry (operands swapped)
	assign cmp_swap = (state_q == ST_FIN_CMP);
	assign cmp_a    = cmp_swap ? ver_q : rdata;
	assign cmp_b    = cmp_swap ? rdata : ver_q;
	assign cmp_lt   = sless(cmp_a, cmp_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			hd_q    <= '0;
			cnt_q   <= '0;
			idx_q   <= '0;
			run_q   <= '0;
		end else begin
			state_q <= state_d;
			hd_q    <= hd_d;
			cnt_q   <= cnt_d;
			idx_q   <= idx_d;
			run_q   <= run_d;
		end
	end

	always_ff @(posedge clk) begin
		ver_q <= ver_d;
	end

	always_comb begin
		state_d = state_q;
		hd_d    = hd_q;
		cnt_d   = cnt_q;
		idx_d   = idx_q;
		run_d   = run_q;
		ver_d   = ver_q;
		we      = 1'b0;
		waddr   = phys(hd_q, idx_q);
		wdata   = ver_q;
		re      = 1'b0;
		raddr   = phys(hd_q, idx_q);
		emit    = '0;

		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					ver_d = version;
					if (operation == OP_START) begin
						if (is_full) begin
							// drop the front entry
							hd_d  = phys(hd_q, CNT_W'(1));
							cnt_d = cnt_q - CNT_W'(1);
							idx_d = cnt_q - CNT_W'(1);
						end else begin
							idx_d = cnt_q;
						end
						state_d = ST_INS_RD;
					end else begin
						idx_d   = '0;
						state_d = ST_FIN_RD;
					end
				end
			end
			ST_INS_RD: begin
				if (idx_q == '0) begin
					we      = 1'b1;
					cnt_d   = cnt_q + CNT_W'(1);
					state_d = ST_ACK;
				end else begin
					re      = 1'b1;
					raddr   = phys(hd_q, idx_m1);
					state_d = ST_INS_CMP;
				end
			end
			ST_INS_CMP: begin
				we = 1'b1;
				if (cmp_lt) begin
					cnt_d   = cnt_q + CNT_W'(1);
					state_d = ST_ACK;
				end else begin
					wdata   = rdata;
					idx_d   = idx_m1;
					state_d = ST_INS_RD;
				end
			end
			ST_ACK: begin
				emit.valid = 1'b1;
				emit.kind  = KIND_INSERT;
				emit.held  = HELD_W'(cnt_q);
				emit.last  = 1'b1;
				if (emit_rdy) begin
					state_d = ST_IDLE;
				end
			end
			ST_FIN_RD: begin
				if (idx_q == cnt_q) begin
					run_d   = idx_q;
					idx_d   = '0;
					state_d = (idx_q == '0) ? ST_NONE : ST_EMIT_RD;
				end else begin
					re      = 1'b1;
					state_d = ST_FIN_CMP;
				end
			end
			ST_FIN_CMP: begin
				if (!cmp_lt) begin
					idx_d   = idx_p1;
					state_d = ST_FIN_RD;
				end else begin
					run_d   = idx_q;
					idx_d   = '0;
					state_d = (idx_q == '0) ? ST_NONE : ST_EMIT_RD;
				end
			end
			ST_NONE: begin
				emit.valid = 1'b1;
				emit.kind  = KIND_NONE;
				emit.held  = HELD_W'(cnt_q);
				emit.last  = 1'b1;
				if (emit_rdy) begin
					state_d = ST_IDLE;
				end
			end
			ST_EMIT_RD: begin
				re      = 1'b1;
				state_d = ST_EMIT_OUT;
			end
			ST_EMIT_OUT: begin
				emit.valid = 1'b1;
				emit.kind  = KIND_REMOVED;
				emit.ver   = rdata;
				emit.held  = HELD_W'(cnt_left);
				emit.last  = last_beat;
				if (emit_rdy) begin
					if (last_beat) begin
						hd_d    = phys(hd_q, run_q);
						cnt_d   = cnt_left;
						state_d = ST_IDLE;
					end else begin
						idx_d   = idx_p1;
						state_d = ST_EMIT_RD;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(LIST_DEPTH))
		else $error("entry count above depth");

	a_write_ins: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (state_q == ST_INS_RD || state_q == ST_INS_CMP))
		else $error("store written outside insertion");

	a_emit_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT_OUT) |-> (run_q != '0 && idx_q < run_q))
		else $error("removal index outside run");

	a_cmp_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN_CMP || state_q == ST_INS_CMP || state_q == ST_EMIT_OUT)
		&& $past(state_q) != state_q |-> $past(re))
		else $error("compare without a preceding read");

endmodule

`default_nettype wire
